### sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/ffha_pkg.sv
// Shared codes and constants for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ALLOC   = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_FREED   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // split threshold beyond the header size, and smallest arena size
    localparam int SPLIT_EXTRA     = 10;
    localparam int ARENA_MIN_BYTES = 64;

    localparam logic [12:0] ARENA_RESET = 13'd4096;

endpackage

### sv/ffha_hdr_ram.sv
// Header RAM: one write port, one read port with registered read data.
// No package dependencies.
module ffha_hdr_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 47
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### sv/first_fit_heap_allocator_core.sv
// First-fit heap allocator: address-ordered chain of headers in one RAM.
// Alloc: walks the chain header by header, writes back (split: new block, next header, chosen
// block; else chosen block only), then the result; out of memory: walk, then the result.
// Free: reads block and neighbours, writes back, then the result; rejected frees end early.
// One item at a time, paced by the header RAM port; a stalled output holds the result.
// Reset and arena_bytes_we clear the header RAM before any item. Uses ffha_pkg, ffha_hdr_ram.
module first_fit_heap_allocator_core #(
    parameter int ARENA_WORDS  = 1024,
    parameter int HEADER_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        arena_bytes_we,
    input  logic [12:0] arena_bytes,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [12:0] request_bytes,
    input  logic [7:0]  owner_tag,
    input  logic [11:0] block_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] payload_offset,
    output logic [1:0]  status,
    output logic [8:0]  block_count,
    output logic [12:0] tail_low_water
);
    import ffha_pkg::*;

    localparam int CAP  = 4 * ARENA_WORDS;
    localparam int AW   = $clog2(CAP);
    localparam int LW   = $clog2(CAP + 1);
    localparam int XW   = LW + 8;
    localparam int CW   = AW + 1;
    localparam int LO_A = (2 * HEADER_BYTES + 4 > ARENA_MIN_BYTES) ?
                          2 * HEADER_BYTES + 4 : ARENA_MIN_BYTES;
    localparam logic [XW-1:0] CAP_X   = XW'(CAP);
    localparam logic [XW-1:0] HDR_X   = XW'(HEADER_BYTES);
    localparam logic [XW-1:0] LO_X    = XW'(LO_A);
    localparam logic [XW-1:0] SPLIT_X = XW'(SPLIT_EXTRA + HEADER_BYTES);
    localparam logic [XW-1:0] SMALL_E = (CAP > 4) ? XW'(4) : '0;

    typedef struct packed {
        logic          mark;
        logic          occ;
        logic [7:0]    own;
        logic [AW-1:0] prv;
        logic [AW-1:0] nxt;
        logic [LW-1:0] len;
    } hdr_t;

    localparam int DW = $bits(hdr_t);

    typedef enum logic [4:0] {
        S_CLR, S_INIT0, S_INITE, S_IDLE,
        S_A_EVAL, S_A_WM, S_A_WN, S_A_WC,
        S_F_EVA, S_F_EVP, S_F_EVN, S_F_WA, S_F_WN2, S_F_WP,
        S_RES
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] clr_idx_reg;
    logic [XW-1:0] arena_reg;
    logic [AW-1:0] end_reg;
    logic [CW-1:0] count_reg;
    logic [LW-1:0] tail_reg;
    logic [AW-1:0] cur_reg;
    logic [XW-1:0] rl_reg;
    logic [7:0]    owner_reg;
    hdr_t          blk_reg;
    logic          split_reg;
    logic [AW-1:0] m_reg;
    logic [AW-1:0] n_reg;
    logic [AW-1:0] act_reg;
    hdr_t          act_w_reg;
    logic [AW-1:0] p_reg;
    hdr_t          p_w_reg;
    logic [AW-1:0] n2_reg;
    logic          relink_reg;
    logic [11:0]   res_off_reg;
    logic [1:0]    res_st_reg;
    logic          out_valid_reg;
    logic [11:0]   out_off_reg;
    logic [1:0]    out_st_reg;
    logic [8:0]    out_cnt_reg;
    logic [12:0]   out_tail_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    hdr_t          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;
    hdr_t          rd_w;

    logic [XW-1:0] cfg_x, a_sat, e_x, e_fix;
    logic [AW-1:0] lay_e;
    logic [LW-1:0] lay_len;
    logic [XW-1:0] off_x, act_x, rl_in, m_x, rem_x, mlen_x, plen_x;
    logic          bad_idle, fit, split_ok, merge;
    logic [AW-1:0] wc_nxt;
    logic          in_acc, out_free;

    assign rd_w = hdr_t'(ram_rdata);

    // arena size saturation and layout of start block and end sentinel
    always_comb
    begin
        cfg_x = XW'(arena_bytes);
        a_sat = cfg_x;
        if (a_sat < LO_X)
        begin
            a_sat = LO_X;
        end
        if (a_sat > CAP_X)
        begin
            a_sat = CAP_X;
        end
        e_x = (arena_reg >= HDR_X) ? ((arena_reg - HDR_X) & ~XW'(3)) : '0;
        e_fix = (e_x == '0) ? SMALL_E : e_x;
        if (e_fix >= CAP_X)
        begin
            e_fix = CAP_X - XW'(1);
        end
        lay_e   = e_fix[AW-1:0];
        lay_len = (e_fix >= HDR_X) ? LW'(e_fix - HDR_X) : '0;
    end

    // request decode and per-header checks
    always_comb
    begin
        off_x    = XW'(block_offset);
        act_x    = off_x - HDR_X;
        bad_idle = (off_x < HDR_X) || (act_x >= CAP_X) || (act_x[AW-1:0] == end_reg);
        rl_in    = (XW'(request_bytes) + XW'(3)) & ~XW'(3);
        fit      = !rd_w.occ && (XW'(rd_w.len) >= rl_reg);
        rem_x    = XW'(rd_w.len) - rl_reg;
        m_x      = XW'(cur_reg) + rl_reg + HDR_X;
        split_ok = (rem_x >= SPLIT_X) && (m_x < CAP_X);
        mlen_x   = XW'(n_reg) - XW'(m_reg) - HDR_X;
        plen_x   = XW'(n2_reg) - XW'(p_reg) - HDR_X;
        merge    = (act_w_reg.nxt != end_reg) && !rd_w.occ;
        wc_nxt   = split_reg ? m_reg : blk_reg.nxt;
    end

    // header RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = rd_w;
        ram_raddr = cur_reg;
        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
            end
            S_INIT0:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{mark: 1'b1, occ: 1'b0, own: '0, prv: '0,
                              nxt: lay_e, len: lay_len};
            end
            S_INITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = lay_e;
                ram_wdata = '{mark: 1'b1, occ: 1'b1, own: '0, prv: '0,
                              nxt: lay_e, len: LW'(arena_reg)};
            end
            S_IDLE:
            begin
                ram_raddr = (cmd == CMD_FREE) ? act_x[AW-1:0] : '0;
            end
            S_A_EVAL:
            begin
                ram_raddr = rd_w.nxt;
            end
            S_A_WM:
            begin
                ram_we    = 1'b1;
                ram_waddr = m_reg;
                ram_wdata = '{mark: 1'b1, occ: 1'b0, own: '0, prv: cur_reg,
                              nxt: n_reg, len: LW'(mlen_x)};
                ram_raddr = n_reg;
            end
            S_A_WN:
            begin
                ram_we        = 1'b1;
                ram_waddr     = n_reg;
                ram_wdata     = rd_w;
                ram_wdata.prv = m_reg;
            end
            S_A_WC:
            begin
                ram_we        = 1'b1;
                ram_waddr     = cur_reg;
                ram_wdata     = blk_reg;
                ram_wdata.occ = 1'b1;
                ram_wdata.own = owner_reg;
                ram_wdata.nxt = wc_nxt;
                if (split_reg)
                begin
                    ram_wdata.len = LW'(rl_reg);
                end
            end
            S_F_EVA:
            begin
                ram_raddr = rd_w.prv;
            end
            S_F_EVP:
            begin
                ram_raddr = act_w_reg.nxt;
            end
            S_F_EVN:
            begin
                ram_we         = merge;
                ram_waddr      = act_w_reg.nxt;
                ram_wdata      = rd_w;
                ram_wdata.mark = 1'b0;
            end
            S_F_WA:
            begin
                ram_we         = (p_reg != act_reg);
                ram_waddr      = act_reg;
                ram_wdata      = act_w_reg;
                ram_wdata.mark = 1'b0;
                ram_raddr      = n2_reg;
            end
            S_F_WN2:
            begin
                ram_we        = (p_w_reg.nxt != n2_reg);
                ram_waddr     = n2_reg;
                ram_wdata     = rd_w;
                ram_wdata.prv = p_reg;
            end
            S_F_WP:
            begin
                ram_we        = 1'b1;
                ram_waddr     = p_reg;
                ram_wdata     = p_w_reg;
                ram_wdata.own = '0;
                ram_wdata.occ = 1'b0;
                if (relink_reg)
                begin
                    ram_wdata.nxt = n2_reg;
                    ram_wdata.len = LW'(plen_x);
                end
            end
            S_RES:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    ffha_hdr_ram #(
        .DEPTH (CAP),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_acc   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // sequencer, allocator state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_idx_reg   <= '0;
            arena_reg     <= (XW'(ARENA_RESET) > CAP_X) ? CAP_X : XW'(ARENA_RESET);
            end_reg       <= '0;
            count_reg     <= CW'(1);
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop a delivered result unless a new one is loaded in S_RES
            if (out_valid_reg && !out_stall && ((state_reg != S_RES) || arena_bytes_we))
            begin
                out_valid_reg <= 1'b0;
            end
            if (arena_bytes_we)
            begin
                arena_reg   <= a_sat;
                state_reg   <= S_CLR;
                clr_idx_reg <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_CLR:
                    begin
                        clr_idx_reg <= clr_idx_reg + AW'(1);
                        if (clr_idx_reg == AW'(CAP - 1))
                        begin
                            state_reg <= S_INIT0;
                        end
                    end
                    S_INIT0:
                    begin
                        state_reg <= S_INITE;
                    end
                    S_INITE:
                    begin
                        end_reg   <= lay_e;
                        count_reg <= CW'(1);
                        tail_reg  <= LW'(arena_reg);
                        state_reg <= S_IDLE;
                    end
                    S_IDLE:
                    begin
                        if (in_acc)
                        begin
                            cur_reg   <= '0;
                            rl_reg    <= rl_in;
                            owner_reg <= owner_tag;
                            act_reg   <= act_x[AW-1:0];
                            res_off_reg <= '0;
                            if (cmd == CMD_ALLOC)
                            begin
                                if (end_reg == '0)
                                begin
                                    res_st_reg <= ST_OOM;
                                    state_reg  <= S_RES;
                                end
                                else
                                begin
                                    state_reg <= S_A_EVAL;
                                end
                            end
                            else if (bad_idle)
                            begin
                                res_st_reg <= ST_INVALID;
                                state_reg  <= S_RES;
                            end
                            else
                            begin
                                state_reg <= S_F_EVA;
                            end
                        end
                    end
                    // first-fit walk, one header per cycle
                    S_A_EVAL:
                    begin
                        if (fit)
                        begin
                            blk_reg   <= rd_w;
                            split_reg <= split_ok;
                            m_reg     <= m_x[AW-1:0];
                            n_reg     <= rd_w.nxt;
                            state_reg <= split_ok ? S_A_WM : S_A_WC;
                        end
                        else if (rd_w.nxt == end_reg)
                        begin
                            res_st_reg <= ST_OOM;
                            state_reg  <= S_RES;
                        end
                        else
                        begin
                            cur_reg <= rd_w.nxt;
                        end
                    end
                    S_A_WM:
                    begin
                        count_reg <= count_reg + CW'(1);
                        if ((n_reg == end_reg) && (LW'(mlen_x) < tail_reg))
                        begin
                            tail_reg <= LW'(mlen_x);
                        end
                        state_reg <= S_A_WN;
                    end
                    S_A_WN:
                    begin
                        state_reg <= S_A_WC;
                    end
                    S_A_WC:
                    begin
                        if (wc_nxt == end_reg)
                        begin
                            tail_reg <= '0;
                        end
                        res_off_reg <= 12'(XW'(cur_reg) + HDR_X);
                        res_st_reg  <= ST_ALLOC;
                        state_reg   <= S_RES;
                    end
                    // free: check block, then previous and next neighbors
                    S_F_EVA:
                    begin
                        act_w_reg <= rd_w;
                        if (!rd_w.mark || !rd_w.occ)
                        begin
                            res_st_reg <= ST_INVALID;
                            state_reg  <= S_RES;
                        end
                        else
                        begin
                            state_reg <= S_F_EVP;
                        end
                    end
                    S_F_EVP:
                    begin
                        if ((act_reg != '0) && !rd_w.occ)
                        begin
                            p_reg   <= act_w_reg.prv;
                            p_w_reg <= rd_w;
                        end
                        else
                        begin
                            p_reg   <= act_reg;
                            p_w_reg <= act_w_reg;
                        end
                        state_reg <= S_F_EVN;
                    end
                    S_F_EVN:
                    begin
                        if (merge)
                        begin
                            count_reg <= count_reg - CW'(1);
                            n2_reg    <= rd_w.nxt;
                        end
                        else
                        begin
                            n2_reg <= act_w_reg.nxt;
                        end
                        state_reg <= S_F_WA;
                    end
                    S_F_WA:
                    begin
                        if (p_reg != act_reg)
                        begin
                            count_reg <= count_reg - CW'(1);
                        end
                        state_reg <= S_F_WN2;
                    end
                    S_F_WN2:
                    begin
                        relink_reg <= (p_w_reg.nxt != n2_reg);
                        state_reg  <= S_F_WP;
                    end
                    S_F_WP:
                    begin
                        res_st_reg <= ST_FREED;
                        state_reg  <= S_RES;
                    end
                    // hand the result to the output register
                    S_RES:
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            out_off_reg   <= res_off_reg;
                            out_st_reg    <= res_st_reg;
                            out_cnt_reg   <= count_reg[8:0];
                            out_tail_reg  <= 13'(tail_reg);
                            state_reg     <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign payload_offset = out_off_reg;
    assign status         = out_st_reg;
    assign block_count    = out_cnt_reg;
    assign tail_low_water = out_tail_reg;

endmodule

### sv/ffha_checker.sv
// Port-level checks for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] payload_offset,
    input logic [1:0]  status
);
    import ffha_pkg::*;

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // one item at a time: busy right after a transfer in
    `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)

    // only a successful allocate carries a payload offset
    `ASSERT_IMPL(a_zero_payload, clk, rst_n,
        out_valid && (status == ST_OOM || status == ST_FREED || status == ST_INVALID),
        payload_offset == 12'd0)

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .payload_offset (payload_offset),
    .status         (status)
);

### verif/tb.sv
// Self-checking bench for first_fit_heap_allocator_core: a queue-fed driver and a monitor
// that check each result against a built-in model of the headed block chain.
// Depends on ffha_pkg and the core RTL.
module tb;
    import ffha_pkg::*;

    localparam int ARENA_WORDS  = 1024;
    localparam int HEADER_BYTES = 16;
    localparam int CAP          = 4 * ARENA_WORDS;
    localparam int SPLIT_MIN    = SPLIT_EXTRA + HEADER_BYTES;

    typedef struct {
        logic        cmd;
        logic [12:0] req;
        logic [7:0]  owner;
        logic [11:0] offs;
    } heap_req_t;

    typedef struct {
        logic [11:0] payload;
        logic [1:0]  st;
        logic [8:0]  count;
        logic [12:0] low_water;
    } heap_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [12:0] cfg_data = ARENA_RESET;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = CMD_ALLOC;
    logic [12:0] request_bytes = '0;
    logic [7:0]  owner_tag = '0;
    logic [11:0] block_offset = '0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic [11:0] payload_offset;
    logic [1:0]  status;
    logic [8:0]  block_count;
    logic [12:0] tail_low_water;

    // heap shadow: one header per byte position
    int unsigned blk_len[CAP];
    int unsigned blk_next[CAP];
    int unsigned blk_prev[CAP];
    bit          blk_used[CAP];
    bit          blk_start[CAP];
    int unsigned n_blocks;
    int unsigned sentinel;

    heap_req_t   pending_reqs[$];
    heap_rsp_t   due_rsps[$];
    logic [11:0] live_payloads[$];
    heap_req_t   cur_req;
    bit          failed = 1'b0;
    int          send_idle = 16;
    int          recv_idle = 80;
    bit          long_hold = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    first_fit_heap_allocator_core #(
        .ARENA_WORDS(ARENA_WORDS),
        .HEADER_BYTES(HEADER_BYTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .arena_bytes_we(cfg_we),
        .arena_bytes(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .request_bytes(request_bytes),
        .owner_tag(owner_tag),
        .block_offset(block_offset),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .payload_offset(payload_offset),
        .status(status),
        .block_count(block_count),
        .tail_low_water(tail_low_water)
    );

    always #10 clk = ~clk;

    // lay the arena out as one free block plus the end sentinel
    function automatic void build_heap(input int unsigned size_in);
        int unsigned lo;
        int unsigned a;
        int unsigned e;
        lo = 64;
        a = size_in;
        if (2 * HEADER_BYTES + 4 > lo) lo = 2 * HEADER_BYTES + 4;
        if (a < lo) a = lo;
        if (a > CAP) a = CAP;
        e = (a >= HEADER_BYTES) ? ((a - HEADER_BYTES) & ~32'd3) : 0;
        if (e == 0) e = (CAP > 4) ? 4 : 0;
        if (e >= CAP) e = CAP - 1;
        sentinel = e;
        for (int i = 0; i < CAP; i++)
        begin
            blk_len[i] = 0;
            blk_next[i] = 0;
            blk_prev[i] = 0;
            blk_used[i] = 1'b0;
            blk_start[i] = 1'b0;
        end
        blk_next[0] = e;
        blk_len[0] = (e >= HEADER_BYTES) ? e - HEADER_BYTES : 0;
        blk_start[0] = 1'b1;
        blk_next[e] = e;
        blk_len[e] = a;
        blk_used[e] = 1'b1;
        blk_start[e] = 1'b1;
        n_blocks = 1;
        live_payloads.delete();
    endfunction

    // first-fit search with split; returns status, payload via output
    function automatic logic [1:0] heap_alloc(input int unsigned req,
                                              output int unsigned payload);
        int unsigned rl;
        int unsigned cur;
        int unsigned m;
        int unsigned n;
        rl = (req + 3) & ~32'd3;
        cur = 0;
        payload = 0;
        for (int steps = 0; steps < CAP && cur < CAP && cur != sentinel; steps++)
        begin
            if (!blk_used[cur] && blk_len[cur] >= rl)
            begin
                if (blk_len[cur] - rl >= SPLIT_MIN)
                begin
                    m = cur + rl + HEADER_BYTES;
                    n = blk_next[cur];
                    if (m < CAP && n < CAP)
                    begin
                        blk_next[m] = n;
                        blk_prev[n] = m;
                        blk_len[m] = n - m - HEADER_BYTES;
                        blk_used[m] = 1'b0;
                        blk_prev[m] = cur;
                        blk_start[m] = 1'b1;
                        blk_next[cur] = m;
                        blk_len[cur] = rl;
                        n_blocks++;
                        if (n == sentinel && blk_len[m] < blk_len[n]) blk_len[n] = blk_len[m];
                    end
                end
                blk_used[cur] = 1'b1;
                if (blk_next[cur] == sentinel) blk_len[sentinel] = 0;
                payload = cur + HEADER_BYTES;
                return ST_ALLOC;
            end
            cur = blk_next[cur];
        end
        return ST_OOM;
    endfunction

    // release with merge of free neighbours
    function automatic logic [1:0] heap_release(input int unsigned offs);
        int unsigned act;
        int unsigned p;
        int unsigned n;
        int unsigned q;
        if (offs < HEADER_BYTES) return ST_INVALID;
        act = offs - HEADER_BYTES;
        if (act >= CAP || act == sentinel || !blk_start[act] || !blk_used[act])
            return ST_INVALID;
        p = act;
        if (act != 0)
        begin
            q = blk_prev[act];
            if (q < CAP && !blk_used[q]) p = q;
        end
        n = blk_next[act];
        if (n < CAP && n != sentinel && !blk_used[n])
        begin
            blk_start[n] = 1'b0;
            n_blocks--;
            n = blk_next[n];
        end
        if (p != act)
        begin
            blk_start[act] = 1'b0;
            n_blocks--;
        end
        if (n < CAP && blk_next[p] != n)
        begin
            blk_next[p] = n;
            blk_prev[n] = p;
            blk_len[p] = n - p - HEADER_BYTES;
        end
        blk_used[p] = 1'b0;
        return ST_FREED;
    endfunction

    // apply one accepted transfer to the shadow heap and queue its result
    function automatic void heap_apply(input heap_req_t r);
        heap_rsp_t   rsp;
        int unsigned pay;
        pay = 0;
        if (r.cmd == CMD_ALLOC)
        begin
            rsp.st = heap_alloc(r.req, pay);
            if (rsp.st == ST_ALLOC) live_payloads.push_back(pay[11:0]);
        end
        else
        begin
            rsp.st = heap_release(r.offs);
            if (rsp.st == ST_FREED)
                foreach (live_payloads[i])
                    if (live_payloads[i] == r.offs)
                    begin
                        live_payloads.delete(i);
                        break;
                    end
        end
        rsp.payload = pay[11:0];
        rsp.count = n_blocks[8:0];
        rsp.low_water = blk_len[sentinel][12:0];
        due_rsps.push_back(rsp);
    endfunction

    // driver: one request transfer in flight at a time
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            bit free_slot;
            free_slot = !in_valid;
            if (in_valid && !in_stall)
            begin
                heap_apply(cur_req);
                free_slot = 1'b1;
            end
            if (free_slot)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    cur_req = pending_reqs.pop_front();
                    cmd <= cur_req.cmd;
                    request_bytes <= cur_req.req;
                    owner_tag <= cur_req.owner;
                    block_offset <= cur_req.offs;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (long_hold && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 600;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            heap_rsp_t want;
            if (due_rsps.size() == 0)
            begin
                $display("%0t: unexpected result payload=%0d status=%0d", $time,
                         payload_offset, status);
                failed = 1'b1;
            end
            else
            begin
                want = due_rsps.pop_front();
                if (payload_offset !== want.payload)
                begin
                    $display("%0t: payload_offset exp %0d got %0d", $time, want.payload,
                             payload_offset);
                    failed = 1'b1;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.st, status);
                    failed = 1'b1;
                end
                if (block_count !== want.count)
                begin
                    $display("%0t: block_count exp %0d got %0d", $time, want.count,
                             block_count);
                    failed = 1'b1;
                end
                if (tail_low_water !== want.low_water)
                begin
                    $display("%0t: tail_low_water exp %0d got %0d", $time,
                             want.low_water, tail_low_water);
                    failed = 1'b1;
                end
            end
        end
    end

    // hard stop
    initial
    begin
        #400000000;
        $display("tb: failure");
        $finish;
    end

    task automatic push_req(input logic c, input int unsigned req, input int unsigned own,
                            input int unsigned offs);
        heap_req_t r;
        r.cmd = c;
        r.req = req[12:0];
        r.owner = own[7:0];
        r.offs = offs[11:0];
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || due_rsps.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_arena(input int unsigned size_in);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= size_in[12:0];
        build_heap(size_in);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random traffic: mostly real alloc/free pairs, some junk frees
    task automatic random_traffic(input int count);
        int unsigned sel;
        int unsigned sz;
        for (int i = 0; i < count; i++)
        begin
            while (pending_reqs.size() > 4) @(posedge clk);
            sel = $urandom_range(99);
            if (sel < 55)
            begin
                sz = ($urandom_range(19) == 0) ? $urandom_range(8191) : $urandom_range(160);
                push_req(CMD_ALLOC, sz, $urandom_range(255), $urandom_range(4095));
            end
            else if (sel < 90 && live_payloads.size() > 0)
            begin
                push_req(CMD_FREE, $urandom_range(8191), $urandom_range(255),
                         live_payloads[$urandom_range(live_payloads.size() - 1)]);
            end
            else
            begin
                push_req(CMD_FREE, $urandom_range(8191), $urandom_range(255),
                         $urandom_range(4095));
            end
        end
    endtask

    initial
    begin
        int unsigned arena_sizes[7];
        arena_sizes = '{64, 8191, 0, 200, 1000, 4096, 37};
        build_heap(ARENA_RESET);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: size extremes, owner extremes, bad frees, coalescing
        push_req(CMD_ALLOC, 0, 0, 0);
        push_req(CMD_ALLOC, 1, 255, 4095);
        push_req(CMD_ALLOC, 100, 85, 0);
        push_req(CMD_ALLOC, 8191, 170, 0);
        push_req(CMD_ALLOC, 4096, 1, 0);
        push_req(CMD_FREE, 0, 0, 0);
        push_req(CMD_FREE, 0, 0, 15);
        push_req(CMD_FREE, 0, 0, 4095);
        push_req(CMD_FREE, 0, 0, 16 + 16 + 4);
        push_req(CMD_FREE, 0, 0, 16 + 16 + 4);
        push_req(CMD_FREE, 8191, 255, 16);
        push_req(CMD_FREE, 0, 0, 16 + 16 + 4 + 16 + 4);
        push_req(CMD_ALLOC, 3980, 7, 0);
        push_req(CMD_ALLOC, 4000, 7, 0);
        wait_drained();

        // small arena: sentinel free and whole-tail allocation
        write_arena(64);
        push_req(CMD_FREE, 0, 0, 64);
        push_req(CMD_ALLOC, 32, 9, 0);
        push_req(CMD_ALLOC, 0, 9, 0);
        push_req(CMD_FREE, 0, 0, 16);
        push_req(CMD_ALLOC, 4, 9, 0);
        wait_drained();

        // random phases across arena sizes and idle patterns
        for (int k = 0; k < 7; k++)
        begin
            write_arena(arena_sizes[k]);
            case (k % 3)
                0: begin send_idle = 16; recv_idle = 80; end
                1: begin send_idle = 80; recv_idle = 16; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            if (k == 5)
            begin
                send_idle = 0;
                long_hold = 1'b1;
            end
            random_traffic(210);
            wait_drained();
        end

        repeat (300) @(posedge clk);
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
